[hw/rtl/bright_target_projection_peak_macros.svh]
// ----------------------------------------------------------------------------
// Bright target projection peak: assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BRIGHT_TARGET_PROJECTION_PEAK_MACROS_SVH
`define BRIGHT_TARGET_PROJECTION_PEAK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTPP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/btpp_pkg.sv]
// ----------------------------------------------------------------------------
// Bright target projection peak package
// Field widths, default bounds, register indexes and reset values shared by the block.
// ----------------------------------------------------------------------------
package btpp_pkg;

    // Field widths.
    localparam int PIX_W      = 8;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int IDX_OUT_W  = 10;
    // Wide enough for any clamped frame size (up to 2047) plus one.
    localparam int SIZE_W     = 13;

    // Default array bounds.
    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_MAX_ROWS    = 1024;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH      = 2'd0,
        CFG_FRAME_HEIGHT     = 2'd1,
        CFG_BRIGHT_THRESHOLD = 2'd2
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH      = 11'd960;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT     = 11'd720;
    localparam logic [PIX_W-1:0]      RST_BRIGHT_THRESHOLD = 8'd250;

endpackage

[hw/rtl/btpp_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module btpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; a same-cycle write is not seen until the next read.
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/bright_target_projection_peak.sv]
// ----------------------------------------------------------------------------
// Bright target projection peak
// Counts bright pixels per row and column and reports the peak of each.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one item per clock when both sides keep up;
// the sustained rate is one pixel per cycle. Each pixel reads its column count
// from a RAM with a registered read, adds its bright bit one stage later and
// writes it back; the write of the previous pixel is forwarded when it hits
// the same column, so a one-pixel-wide frame also runs at full rate. The
// result of a frame is loaded into the output register when its last pixel
// leaves stage one. The input stalls only while the last pixel of a frame
// waits behind a previous result that has not been taken. The column RAM
// needs no clearing pass: the first row of every frame overwrites the counts
// instead of adding to them. Configuration should be written between frames
// or while the block is idle.
// ----------------------------------------------------------------------------
module bright_target_projection_peak #(
    parameter int MAX_COLUMNS = btpp_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = btpp_pkg::DEF_MAX_ROWS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [btpp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [btpp_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Pixel input.
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [btpp_pkg::PIX_W-1:0]       s_blue,
    input  logic [btpp_pkg::PIX_W-1:0]       s_green,
    input  logic [btpp_pkg::PIX_W-1:0]       s_red,
    // Result output.
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_found,
    output logic [btpp_pkg::IDX_OUT_W-1:0]   m_peak_column,
    output logic [btpp_pkg::IDX_OUT_W-1:0]   m_peak_row
);

    import btpp_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    // A column count goes up to the number of rows, a row count up to columns.
    localparam int CCNT_W = $clog2(MAX_ROWS + 1);
    localparam int RCNT_W = $clog2(MAX_COLUMNS + 1);

    // Pixel in flight between the RAM read and the write-back.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             bright;
        logic             first_row;
        logic             end_row;
        logic             end_frame;
    } st1_t;

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [CFG_DATA_W-1:0] v,
        input logic [SIZE_W-1:0]     lim
    );
        logic [SIZE_W-1:0] ext;
        ext = SIZE_W'(v);
        if (ext == '0) begin
            return SIZE_W'(1);
        end
        if (ext > lim) begin
            return lim;
        end
        return ext;
    endfunction

    // Configuration registers.
    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;
    logic [PIX_W-1:0]      bright_threshold_reg;

    // Raster position.
    logic [COL_W-1:0] col_pos_reg, col_pos_next;
    logic [ROW_W-1:0] row_pos_reg, row_pos_next;

    // Stage one and forwarding.
    logic              st1_valid_reg, st1_valid_next;
    st1_t              st1_reg, st1_next;
    logic              fwd_hit_reg, fwd_hit_next;
    logic [CCNT_W-1:0] fwd_data_reg;

    // Per-frame statistics.
    logic [RCNT_W-1:0] cur_row_cnt_reg, cur_row_cnt_next;
    logic [RCNT_W-1:0] best_row_cnt_reg, best_row_cnt_next;
    logic [ROW_W-1:0]  best_row_idx_reg, best_row_idx_next;
    logic [CCNT_W-1:0] best_col_cnt_reg, best_col_cnt_next;
    logic [COL_W-1:0]  best_col_idx_reg, best_col_idx_next;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    logic                 found_reg;
    logic [IDX_OUT_W-1:0] peak_col_reg;
    logic [IDX_OUT_W-1:0] peak_row_reg;

    logic              accept;
    logic              stall1;
    logic              advance1;
    logic              load_out;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic              end_row0;
    logic              end_frame0;
    logic              bright0;
    logic [CCNT_W-1:0] ram_rd_data;
    logic [CCNT_W-1:0] col_base;
    logic [CCNT_W-1:0] col_count;
    logic              col_win;
    logic [RCNT_W-1:0] row_sum;
    logic              row_win;
    logic [COL_W-1:0]  out_col_idx;
    logic [ROW_W-1:0]  out_row_idx;

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg      <= RST_FRAME_WIDTH;
            frame_height_reg     <= RST_FRAME_HEIGHT;
            bright_threshold_reg <= RST_BRIGHT_THRESHOLD;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_FRAME_WIDTH:      frame_width_reg      <= cfg_data;
                CFG_FRAME_HEIGHT:     frame_height_reg     <= cfg_data;
                CFG_BRIGHT_THRESHOLD: bright_threshold_reg <= cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake. Stage one stalls only when it holds the last pixel of a frame
    // and the previous result is still waiting.
    assign stall1   = st1_valid_reg && st1_reg.end_frame && m_valid_reg && !m_ready;
    assign advance1 = st1_valid_reg && !stall1;
    assign load_out = advance1 && st1_reg.end_frame;
    assign s_ready  = !stall1;
    assign accept   = s_valid && s_ready;

    // Stage zero: classify the pixel and step the raster position.
    always_comb begin
        w_eff      = clamp_size(frame_width_reg, SIZE_W'(MAX_COLUMNS));
        h_eff      = clamp_size(frame_height_reg, SIZE_W'(MAX_ROWS));
        end_row0   = (SIZE_W'(col_pos_reg) + SIZE_W'(1)) >= w_eff;
        end_frame0 = end_row0 && ((SIZE_W'(row_pos_reg) + SIZE_W'(1)) >= h_eff);
        bright0    = (s_blue > bright_threshold_reg) &&
                     (s_green > bright_threshold_reg) &&
                     (s_red > bright_threshold_reg);

        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (accept) begin
            if (end_row0) begin
                col_pos_next = '0;
                row_pos_next = end_frame0 ? '0 : row_pos_reg + ROW_W'(1);
            end else begin
                col_pos_next = col_pos_reg + COL_W'(1);
            end
        end

        st1_next.col       = col_pos_reg;
        st1_next.row       = row_pos_reg;
        st1_next.bright    = bright0;
        st1_next.first_row = (row_pos_reg == '0);
        st1_next.end_row   = end_row0;
        st1_next.end_frame = end_frame0;

        st1_valid_next = accept || stall1;
        // The pixel now in stage one writes its column at this edge.
        fwd_hit_next   = advance1 && (st1_reg.col == col_pos_reg);
    end

    // Column count memory.
    btpp_ram #(
        .WIDTH (CCNT_W),
        .DEPTH (MAX_COLUMNS)
    ) u_col_ram (
        .clk     (aclk),
        .wr_en   (advance1),
        .wr_addr (st1_reg.col),
        .wr_data (col_count),
        .rd_en   (accept),
        .rd_addr (col_pos_reg),
        .rd_data (ram_rd_data)
    );

    // Stage one: update the column count and both argmax trackers.
    always_comb begin
        col_base  = st1_reg.first_row ? '0 : (fwd_hit_reg ? fwd_data_reg : ram_rd_data);
        col_count = col_base + CCNT_W'(st1_reg.bright);
        col_win   = (col_count > best_col_cnt_reg) ||
                    ((col_count == best_col_cnt_reg) && (st1_reg.col < best_col_idx_reg));
        row_sum   = cur_row_cnt_reg + RCNT_W'(st1_reg.bright);
        row_win   = st1_reg.end_row && (row_sum > best_row_cnt_reg);

        out_col_idx = col_win ? st1_reg.col : best_col_idx_reg;
        out_row_idx = row_win ? st1_reg.row : best_row_idx_reg;

        cur_row_cnt_next  = cur_row_cnt_reg;
        best_row_cnt_next = best_row_cnt_reg;
        best_row_idx_next = best_row_idx_reg;
        best_col_cnt_next = best_col_cnt_reg;
        best_col_idx_next = best_col_idx_reg;
        if (advance1) begin
            if (st1_reg.end_frame) begin
                // New frame starts with cleared statistics.
                cur_row_cnt_next  = '0;
                best_row_cnt_next = '0;
                best_row_idx_next = '0;
                best_col_cnt_next = '0;
                best_col_idx_next = '0;
            end else begin
                if (col_win) begin
                    best_col_cnt_next = col_count;
                    best_col_idx_next = st1_reg.col;
                end
                if (st1_reg.end_row) begin
                    cur_row_cnt_next = '0;
                    if (row_win) begin
                        best_row_cnt_next = row_sum;
                        best_row_idx_next = st1_reg.row;
                    end
                end else begin
                    cur_row_cnt_next = row_sum;
                end
            end
        end

        m_valid_next = load_out || (m_valid_reg && !m_ready);
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg      <= '0;
            row_pos_reg      <= '0;
            st1_valid_reg    <= 1'b0;
            fwd_hit_reg      <= 1'b0;
            cur_row_cnt_reg  <= '0;
            best_row_cnt_reg <= '0;
            best_row_idx_reg <= '0;
            best_col_cnt_reg <= '0;
            best_col_idx_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            col_pos_reg      <= col_pos_next;
            row_pos_reg      <= row_pos_next;
            st1_valid_reg    <= st1_valid_next;
            if (accept) begin
                fwd_hit_reg <= fwd_hit_next;
            end
            cur_row_cnt_reg  <= cur_row_cnt_next;
            best_row_cnt_reg <= best_row_cnt_next;
            best_row_idx_reg <= best_row_idx_next;
            best_col_cnt_reg <= best_col_cnt_next;
            best_col_idx_reg <= best_col_idx_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_reg      <= st1_next;
            fwd_data_reg <= col_count;
        end
        if (load_out) begin
            peak_col_reg <= IDX_OUT_W'(out_col_idx);
            peak_row_reg <= IDX_OUT_W'(out_row_idx);
            found_reg    <= (IDX_OUT_W'(out_col_idx) != '0) ||
                            (IDX_OUT_W'(out_row_idx) != '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = found_reg;
    assign m_peak_column = peak_col_reg;
    assign m_peak_row    = peak_row_reg;

endmodule

[hw/rtl/btpp_checker.sv]
// ----------------------------------------------------------------------------
// Bright target projection peak checker
// Port-level assertions on the result channel and input ready, bound to the top level.
// ----------------------------------------------------------------------------
`include "bright_target_projection_peak_macros.svh"

module btpp_checker #(
    parameter int MAX_COLUMNS = btpp_pkg::DEF_MAX_COLUMNS
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_found,
    input logic [btpp_pkg::IDX_OUT_W-1:0]  m_peak_column,
    input logic [btpp_pkg::IDX_OUT_W-1:0]  m_peak_row
);

    import btpp_pkg::*;

    // A waiting result holds its value.
    `BTPP_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_peak_column) && $stable(m_peak_row) && $stable(m_found), "result changed while stalled")

    // Found is clear exactly when both peak indices are zero.
    `BTPP_ASSERT_SAME(a_found_rule, m_valid, m_found == ((m_peak_column != '0) || (m_peak_row != '0)), "found does not match peak indices")

    // The peak column lies inside the column memory.
    `BTPP_ASSERT_SAME(a_column_range, m_valid, int'(m_peak_column) < MAX_COLUMNS, "peak column out of range")

    // Input back-pressure comes only from a blocked result.
    `BTPP_ASSERT_SAME(a_ready_cause, !s_ready, m_valid && !m_ready, "input stalled without a blocked result")

endmodule

bind bright_target_projection_peak btpp_checker #(
    .MAX_COLUMNS (MAX_COLUMNS)
) u_btpp_checker (.*);
